FILE: src/sgr_pkg.sv
`default_nettype none
package sgr_pkg;

  localparam int unsigned FlagW  = 10;
  localparam int unsigned ColorW = 8;
  localparam int unsigned ValueW = 16;

  typedef struct packed {
    logic              bg_intense;
    logic              bg_extended;
    logic [ColorW-1:0] bg_color;
    logic              fg_intense;
    logic              fg_extended;
    logic [ColorW-1:0] fg_color;
    logic [FlagW-1:0]  style_flags;
  } attr_t;

  typedef enum logic [1:0] {
    ERR_NONE          = 2'd0,
    ERR_UNHANDLED     = 2'd1,
    ERR_BAD_SELECTOR  = 2'd2,
    ERR_VALUE_MISSING = 2'd3
  } err_e;

  // pending extended color, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_FG_SEL = 5'b00010,
    PH_FG_IDX = 5'b00100,
    PH_BG_SEL = 5'b01000,
    PH_BG_IDX = 5'b10000
  } phase_e;

  // style flag masks
  localparam logic [FlagW-1:0] FLAG_BOLD      = 10'h001;
  localparam logic [FlagW-1:0] FLAG_FAINT     = 10'h002;
  localparam logic [FlagW-1:0] FLAG_ITALIC    = 10'h004;
  localparam logic [FlagW-1:0] FLAG_UNDERLINE = 10'h008;
  localparam logic [FlagW-1:0] FLAG_BLINKS    = 10'h030;
  localparam logic [FlagW-1:0] FLAG_INVERSE   = 10'h040;
  localparam logic [FlagW-1:0] FLAG_INVISIBLE = 10'h080;
  localparam logic [FlagW-1:0] FLAG_STRIKE    = 10'h100;
  localparam logic [FlagW-1:0] FLAG_FRAKTUR   = 10'h200;

  // SGR codes
  localparam logic [ValueW-1:0] SGR_RESET       = 16'd0;
  localparam logic [ValueW-1:0] SGR_FLAG_FIRST  = 16'd1;
  localparam logic [ValueW-1:0] SGR_ITALIC      = 16'd3;
  localparam logic [ValueW-1:0] SGR_FLAG_LAST   = 16'd9;
  localparam logic [ValueW-1:0] SGR_FRAKTUR     = 16'd20;
  localparam logic [ValueW-1:0] SGR_NO_BOLD     = 16'd21;
  localparam logic [ValueW-1:0] SGR_NORMAL      = 16'd22;
  localparam logic [ValueW-1:0] SGR_NO_ITALIC   = 16'd23;
  localparam logic [ValueW-1:0] SGR_NO_UNDER    = 16'd24;
  localparam logic [ValueW-1:0] SGR_NO_BLINK    = 16'd25;
  localparam logic [ValueW-1:0] SGR_NO_INVERSE  = 16'd27;
  localparam logic [ValueW-1:0] SGR_NO_INVIS    = 16'd28;
  localparam logic [ValueW-1:0] SGR_NO_STRIKE   = 16'd29;
  localparam logic [ValueW-1:0] SGR_FG_BASE     = 16'd30;
  localparam logic [ValueW-1:0] SGR_FG_EXT      = 16'd38;
  localparam logic [ValueW-1:0] SGR_FG_DEFAULT  = 16'd39;
  localparam logic [ValueW-1:0] SGR_BG_BASE     = 16'd40;
  localparam logic [ValueW-1:0] SGR_BG_EXT      = 16'd48;
  localparam logic [ValueW-1:0] SGR_BG_DEFAULT  = 16'd49;
  localparam logic [ValueW-1:0] SGR_FGI_BASE    = 16'd90;
  localparam logic [ValueW-1:0] SGR_FGI_EXT     = 16'd98;
  localparam logic [ValueW-1:0] SGR_FGI_DEFAULT = 16'd99;
  localparam logic [ValueW-1:0] SGR_BGI_BASE    = 16'd100;
  localparam logic [ValueW-1:0] SGR_BGI_EXT     = 16'd108;
  localparam logic [ValueW-1:0] SGR_BGI_DEFAULT = 16'd109;
  localparam logic [ValueW-1:0] SGR_SEL_PALETTE = 16'd5;
  localparam logic [ValueW-1:0] SGR_COLOR_SPAN  = 16'd7;
  localparam logic [ValueW-1:0] COLOR_MAX       = 16'd255;

endpackage
`default_nettype wire

FILE: src/sgr_if.sv
`default_nettype none
interface sgr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] param_value;
  logic        last_in_sequence;
  logic        empty_sequence;

  modport source (output valid, param_value, last_in_sequence, empty_sequence, input ready);
  modport sink   (input valid, param_value, last_in_sequence, empty_sequence, output ready);
endinterface

interface sgr_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] style_flags;
  logic [7:0] fg_color;
  logic       fg_extended;
  logic       fg_intense;
  logic [7:0] bg_color;
  logic       bg_extended;
  logic       bg_intense;
  logic [1:0] error_code;

  modport source (output valid, style_flags, fg_color, fg_extended, fg_intense,
                  bg_color, bg_extended, bg_intense, error_code, input ready);
  modport sink   (input valid, style_flags, fg_color, fg_extended, fg_intense,
                  bg_color, bg_extended, bg_intense, error_code, output ready);
endinterface
`default_nettype wire

FILE: src/sgr_attribute_decoder_core.sv
`default_nettype none
// SGR attribute decoder: takes one SGR parameter per transaction and returns
// the full attribute set after it, plus an error code, one result per
// parameter. Throughput is one parameter per clock unless stalled; results are
// valid the cycle after acceptance. The attribute and extended-color state is
// updated in the same cycle the parameter is accepted, and the result sits in
// an output register, so input is taken whenever that register is empty or
// being drained. Reset leaves all flags clear and both colors at the default.
module sgr_attribute_decoder_core #(
  parameter int unsigned COLOR_BLACK_INDEX   = 1,
  parameter int unsigned COLOR_DEFAULT_INDEX = 0,
  parameter bit          ITALIC_SUPPORTED    = 1'b1
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  sgr_in_if.sink     param_i,
  sgr_out_if.source  attr_o
);
  import sgr_pkg::*;

  localparam logic [ColorW-1:0] DefColor   = ColorW'(COLOR_DEFAULT_INDEX);
  localparam logic [ColorW-1:0] BlackColor = ColorW'(COLOR_BLACK_INDEX);
  localparam logic [FlagW-1:0]  ItalicMask = ITALIC_SUPPORTED ? FLAG_ITALIC : '0;
  localparam attr_t DefAttr = '{bg_intense: 1'b0, bg_extended: 1'b0, bg_color: DefColor,
                                fg_intense: 1'b0, fg_extended: 1'b0, fg_color: DefColor,
                                style_flags: '0};

  attr_t  attr_q, attr_d;
  phase_e phase_q, phase_d;
  err_e   err_d;
  attr_t  res_attr_q;
  err_e   res_err_q;
  logic   out_valid_q;

  logic              in_fire;
  logic [ValueW-1:0] v;
  logic              last;
  logic [ColorW-1:0] pal_idx;
  logic [3:0]        flag_pos;

  assign in_fire       = param_i.valid && param_i.ready;
  assign param_i.ready = !out_valid_q || attr_o.ready;
  assign v             = param_i.param_value;
  assign last          = param_i.last_in_sequence;
  assign pal_idx       = (v > COLOR_MAX) ? ColorW'(COLOR_MAX) : v[ColorW-1:0];
  assign flag_pos      = v[3:0] - 4'd1;

  always_comb begin
    attr_d  = attr_q;
    phase_d = PH_IDLE;
    err_d   = ERR_NONE;
    if (param_i.empty_sequence) begin
      attr_d = DefAttr;
    end else begin
      case (phase_q)
        PH_FG_SEL, PH_BG_SEL: begin
          if (v != SGR_SEL_PALETTE) begin
            err_d = ERR_BAD_SELECTOR;
          end else if (last) begin
            err_d = ERR_VALUE_MISSING;
          end else begin
            phase_d = (phase_q == PH_FG_SEL) ? PH_FG_IDX : PH_BG_IDX;
          end
        end
        PH_FG_IDX: begin
          attr_d.fg_color    = pal_idx;
          attr_d.fg_extended = 1'b1;
        end
        PH_BG_IDX: begin
          attr_d.bg_color    = pal_idx;
          attr_d.bg_extended = 1'b1;
        end
        default: begin
          if (v == SGR_RESET) begin
            attr_d = DefAttr;
          end else if (v >= SGR_FLAG_FIRST && v <= SGR_FLAG_LAST) begin
            if (v == SGR_ITALIC) begin
              attr_d.style_flags = attr_q.style_flags | ItalicMask;
            end else begin
              attr_d.style_flags[flag_pos] = 1'b1;
            end
          end else begin
            case (v)
              SGR_FRAKTUR:    attr_d.style_flags = attr_q.style_flags | FLAG_FRAKTUR;
              SGR_NO_BOLD:    attr_d.style_flags = attr_q.style_flags & ~FLAG_BOLD;
              SGR_NORMAL:     attr_d.style_flags = attr_q.style_flags & ~(FLAG_BOLD | FLAG_FAINT);
              SGR_NO_ITALIC:
                attr_d.style_flags = attr_q.style_flags & ~(FLAG_FRAKTUR | ItalicMask);
              SGR_NO_UNDER:   attr_d.style_flags = attr_q.style_flags & ~FLAG_UNDERLINE;
              SGR_NO_BLINK:   attr_d.style_flags = attr_q.style_flags & ~FLAG_BLINKS;
              SGR_NO_INVERSE: attr_d.style_flags = attr_q.style_flags & ~FLAG_INVERSE;
              SGR_NO_INVIS:   attr_d.style_flags = attr_q.style_flags & ~FLAG_INVISIBLE;
              SGR_NO_STRIKE:  attr_d.style_flags = attr_q.style_flags & ~FLAG_STRIKE;
              SGR_FG_EXT, SGR_FGI_EXT: begin
                attr_d.fg_intense = (v == SGR_FGI_EXT);
                if (last) err_d = ERR_BAD_SELECTOR;
                else phase_d = PH_FG_SEL;
              end
              SGR_BG_EXT, SGR_BGI_EXT: begin
                attr_d.bg_intense = (v == SGR_BGI_EXT);
                if (last) err_d = ERR_BAD_SELECTOR;
                else phase_d = PH_BG_SEL;
              end
              SGR_FG_DEFAULT, SGR_FGI_DEFAULT: begin
                attr_d.fg_color    = DefColor;
                attr_d.fg_extended = 1'b0;
                attr_d.fg_intense  = (v == SGR_FGI_DEFAULT);
              end
              SGR_BG_DEFAULT, SGR_BGI_DEFAULT: begin
                attr_d.bg_color    = DefColor;
                attr_d.bg_extended = 1'b0;
                attr_d.bg_intense  = (v == SGR_BGI_DEFAULT);
              end
              default: begin
                if (v >= SGR_FG_BASE && v <= SGR_FG_BASE + SGR_COLOR_SPAN) begin
                  attr_d.fg_color    = v[ColorW-1:0] - SGR_FG_BASE[ColorW-1:0] + BlackColor;
                  attr_d.fg_extended = 1'b0;
                  attr_d.fg_intense  = 1'b0;
                end else if (v >= SGR_BG_BASE && v <= SGR_BG_BASE + SGR_COLOR_SPAN) begin
                  attr_d.bg_color    = v[ColorW-1:0] - SGR_BG_BASE[ColorW-1:0] + BlackColor;
                  attr_d.bg_extended = 1'b0;
                  attr_d.bg_intense  = 1'b0;
                end else if (v >= SGR_FGI_BASE && v <= SGR_FGI_BASE + SGR_COLOR_SPAN) begin
                  attr_d.fg_color    = v[ColorW-1:0] - SGR_FGI_BASE[ColorW-1:0] + BlackColor;
                  attr_d.fg_extended = 1'b0;
                  attr_d.fg_intense  = 1'b1;
                end else if (v >= SGR_BGI_BASE && v <= SGR_BGI_BASE + SGR_COLOR_SPAN) begin
                  attr_d.bg_color    = v[ColorW-1:0] - SGR_BGI_BASE[ColorW-1:0] + BlackColor;
                  attr_d.bg_extended = 1'b0;
                  attr_d.bg_intense  = 1'b1;
                end else begin
                  err_d = ERR_UNHANDLED;
                end
              end
            endcase
          end
        end
      endcase
    end
    // a sequence never carries a pending extended color past its end
    if (last) phase_d = PH_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= DefAttr;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        attr_q  <= attr_d;
        phase_q <= phase_d;
      end
      if (in_fire) out_valid_q <= 1'b1;
      else if (attr_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_attr_q <= attr_d;
      res_err_q  <= err_d;
    end
  end

  assign attr_o.valid       = out_valid_q;
  assign attr_o.style_flags = res_attr_q.style_flags;
  assign attr_o.fg_color    = res_attr_q.fg_color;
  assign attr_o.fg_extended = res_attr_q.fg_extended;
  assign attr_o.fg_intense  = res_attr_q.fg_intense;
  assign attr_o.bg_color    = res_attr_q.bg_color;
  assign attr_o.bg_extended = res_attr_q.bg_extended;
  assign attr_o.bg_intense  = res_attr_q.bg_intense;
  assign attr_o.error_code  = res_err_q;

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && param_i.last_in_sequence |=> phase_q == PH_IDLE)
    else $error("extended color pending after last parameter");

  a_empty_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && param_i.empty_sequence |=> attr_q == DefAttr && res_err_q == ERR_NONE)
    else $error("empty sequence did not reset attributes");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q && res_attr_q == attr_q)
    else $error("result register out of step with attribute state");

endmodule
`default_nettype wire
